// ===== hw/rtl/page_block_coherence_directory_core_macros.svh =====
// Assertion macros for the coherence directory RTL.
`ifndef PAGE_BLOCK_COHERENCE_DIRECTORY_CORE_MACROS_SVH
`define PAGE_BLOCK_COHERENCE_DIRECTORY_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PBCD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("coherence directory assertion failed");
`define PBCD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("coherence directory assertion failed");
`else
`define PBCD_ASSERT(lbl, clk, rst_n, prop)
`define PBCD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/pbcd_pkg.sv =====
// Types and constants of the page block coherence directory.
`default_nettype none
package pbcd_pkg;

  localparam int OWNER_W = 11;
  localparam int MASK_W  = 32;

  typedef enum logic [3:0] {
    K_SPILL_CPU  = 4'd0,
    K_CPU_WRITE  = 4'd1,
    K_RB_CHECK   = 4'd2,
    K_RB_DONE    = 4'd3,
    K_SPILL_DRAW = 4'd4,
    K_DRAW       = 4'd5,
    K_OWNER_Q    = 4'd6,
    K_STAMP      = 4'd7,
    K_EPOCH_Q    = 4'd8,
    K_DESTROY    = 4'd9
  } kind_t;

  typedef struct packed {
    logic               truth;
    logic               synced;
    logic               partial;
    logic [MASK_W-1:0]  mask;
    logic [OWNER_W-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic [63:0] epoch;
    logic [31:0] cgen;
    logic [31:0] ggen;
  } page_t;

  typedef struct packed {
    logic need;
    logic refute;
  } upd_stat_t;

  typedef struct packed {
    logic        sole;
    logic [7:0]  owner;
    logic [63:0] epoch;
    logic [31:0] refuted;
  } agg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pbcd_row_update.sv =====
// Per-plane modify step applied to one directory row read from memory.
`default_nettype none
module pbcd_row_update import pbcd_pkg::*; #(
  parameter int PLANE_COUNT   = 4,
  parameter int SURFACE_COUNT = 256
) (
  input  wire logic                        walk,
  input  wire logic                        active,
  input  kind_t                            kind,
  input  wire logic [3:0]                  sel,
  input  wire logic [OWNER_W-1:0]          surface,
  input  wire logic                        surface_ok,
  input  wire logic [MASK_W-1:0]           blocks,
  input  wire logic [MASK_W-1:0]           full,
  input  wire logic                        on_edge,
  input  wire logic                        ovf,
  input  entry_t [PLANE_COUNT-1:0]         row_i,
  output entry_t [PLANE_COUNT-1:0]         row_o,
  output upd_stat_t                        stat_o
);

  localparam logic [OWNER_W-1:0] NO_OWNER = OWNER_W'(SURFACE_COUNT);

  always_comb begin
    entry_t            ent;
    logic [MASK_W-1:0] live;
    logic [MASK_W-1:0] shr;
    logic              hit;
    logic              need;
    logic              gran;
    need = 1'b0;
    gran = 1'b0;
    row_o = row_i;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      ent  = row_i[p];
      live = ent.partial ? ent.mask : '1;
      hit  = ((blocks & ~full & live) != '0);
      shr  = live & ~blocks;
      if (walk) begin
        if (surface_ok && ent.owner == surface) begin
          ent.owner = NO_OWNER;
          ent.truth = 1'b0;
          ent.synced = 1'b0;
          ent.partial = 1'b0;
        end
      end else if (active) begin
        case (kind)
          K_RB_DONE: begin
            if (ent.truth) ent.synced = 1'b1;
          end
          K_SPILL_CPU: begin
            if (sel[p] && ent.truth && !ent.synced && (ovf || (on_edge && hit))) need = 1'b1;
          end
          K_CPU_WRITE: begin
            if (sel[p] && ent.truth) begin
              // drop the whole entry unless the write only trims some blocks or touches none
              if (ovf || !on_edge || hit || shr == '0) begin
                ent.owner = NO_OWNER;
                ent.truth = 1'b0;
                ent.synced = 1'b0;
                ent.partial = 1'b0;
              end else if (shr != live) begin
                ent.mask = shr;
                ent.partial = 1'b1;
              end
            end
          end
          K_RB_CHECK: begin
            if (sel[p] && ent.truth && !ent.synced) begin
              gran = 1'b1;
              if (ovf || !ent.partial || !on_edge || (blocks & ent.mask) != '0) need = 1'b1;
            end
          end
          K_SPILL_DRAW: begin
            if (sel[p] && ent.truth && !ent.synced && (!surface_ok || ent.owner != surface))
              need = 1'b1;
          end
          K_DRAW: begin
            if (sel[p] && surface_ok) begin
              ent.owner = surface;
              ent.partial = 1'b0;
              ent.truth = 1'b1;
              ent.synced = 1'b0;
            end
          end
          default: ;
        endcase
      end
      row_o[p] = ent;
    end
    stat_o.need   = need;
    stat_o.refute = active && !walk && (kind == K_RB_CHECK) && gran && !need;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pbcd_agg.sv =====
// Running aggregates: sole owner, maximum epoch and refuted readback count.
`default_nettype none
module pbcd_agg import pbcd_pkg::*; #(
  parameter int PLANE_COUNT   = 4,
  parameter int SURFACE_COUNT = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                commit,
  input  kind_t                    kind,
  input  wire logic                first,
  input  wire logic [3:0]          sel,
  input  entry_t [PLANE_COUNT-1:0] row_i,
  input  wire logic [63:0]         page_epoch,
  input  wire logic                refute,
  output agg_t                     agg_nxt
);

  localparam logic [OWNER_W-1:0] NO_OWNER = OWNER_W'(SURFACE_COUNT);

  logic [OWNER_W-1:0] own_r, own_nxt;
  logic               split_r, split_nxt;
  logic [63:0]        ep_r, ep_nxt;
  logic [31:0]        ref_r, ref_nxt;

  always_comb begin
    own_nxt   = own_r;
    split_nxt = split_r;
    ep_nxt    = ep_r;
    ref_nxt   = ref_r;
    if (commit) begin
      case (kind)
        K_OWNER_Q: begin
          if (first) begin
            own_nxt = NO_OWNER;
            split_nxt = 1'b0;
          end
          for (int p = 0; p < PLANE_COUNT; p++) begin
            if (!split_nxt && sel[p]) begin
              if (row_i[p].owner == NO_OWNER || !row_i[p].truth ||
                  (row_i[p].partial && row_i[p].mask != '1))
                split_nxt = 1'b1;
              else if (own_nxt == NO_OWNER)
                own_nxt = row_i[p].owner;
              else if (row_i[p].owner != own_nxt)
                split_nxt = 1'b1;
            end
          end
        end
        K_EPOCH_Q: begin
          if (first) ep_nxt = '0;
          if (page_epoch > ep_nxt) ep_nxt = page_epoch;
        end
        K_RB_CHECK: begin
          if (refute) ref_nxt = ref_r + 32'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r   <= NO_OWNER;
      split_r <= 1'b0;
      ep_r    <= '0;
      ref_r   <= '0;
    end else begin
      own_r   <= own_nxt;
      split_r <= split_nxt;
      ep_r    <= ep_nxt;
      ref_r   <= ref_nxt;
    end
  end

  always_comb begin
    agg_nxt.sole    = !split_nxt && own_nxt != NO_OWNER;
    agg_nxt.owner   = agg_nxt.sole ? own_nxt[7:0] : 8'd0;
    agg_nxt.epoch   = ep_nxt;
    agg_nxt.refuted = ref_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/page_block_coherence_directory_core.sv =====
// Top level of the page block coherence directory: memories, sequencer, result register.
//   channel  | ports               | direction | transaction
//   in       | in_valid / in_ready | input     | one page event
//   out      | out_valid/out_ready | output    | one result per event
// A page event reads the row and page memories on accept, then modifies, writes back and loads the result.
// Destroy with an in-range surface walks every page row through the row memory port.
// After reset a clearing pass writes every row and page word, with in_ready low.
// A finished result waits in the output register while the next event is taken;
// the modify step holds while that register is still full.
`default_nettype none
module page_block_coherence_directory_core import pbcd_pkg::*; #(
  parameter int PAGE_COUNT    = 512,
  parameter int PLANE_COUNT   = 4,
  parameter int SURFACE_COUNT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_kind,
  input  wire logic [8:0]  in_page,
  input  wire logic [3:0]  in_plane_select,
  input  wire logic [7:0]  in_surface,
  input  wire logic [31:0] in_edge_blocks,
  input  wire logic [31:0] in_edge_full,
  input  wire logic        in_on_edge,
  input  wire logic        in_overflowed,
  input  wire logic        in_first,
  input  wire logic [63:0] in_epoch,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_need,
  output logic             out_owner_valid,
  output logic [7:0]       out_owner,
  output logic [63:0]      out_max_epoch,
  output logic [31:0]      out_refuted_count,
  output logic [31:0]      out_cpu_writes,
  output logic [31:0]      out_gpu_writes
);

`include "page_block_coherence_directory_core_macros.svh"

  localparam int PW = $clog2(PAGE_COUNT);
  localparam logic [PW-1:0] LAST = PW'(PAGE_COUNT - 1);
  localparam logic [OWNER_W-1:0] NO_OWNER = OWNER_W'(SURFACE_COUNT);
  localparam entry_t RST_ENT = '{truth: 1'b0, synced: 1'b0, partial: 1'b0,
                                 mask: '0, owner: NO_OWNER};

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_EXEC, S_WALK, S_DONE} state_t;

  state_t state_r;
  logic [PW-1:0] cnt_r;

  // held transaction
  kind_t         kind_r;
  logic [PW-1:0] idx_r;
  logic [3:0]    sel_r;
  logic [7:0]    surf_r;
  logic [31:0]   blocks_r, full_r;
  logic          edge_r, ovf_r, first_r, in_range_r, surf_ok_r;
  logic [63:0]   epoch_r;

  entry_t [PLANE_COUNT-1:0] row_mem [PAGE_COUNT];
  entry_t [PLANE_COUNT-1:0] row_q, row_upd, row_wd, rst_row;
  page_t                    page_mem [PAGE_COUNT];
  page_t                    page_q, page_upd, page_wd;

  logic          accept, destroy_go, in_range_in, surf_ok_in;
  logic [PW-1:0] idx_in;
  logic          row_rd, row_we, page_we, out_free, go, active, load, walk_step;
  logic [PW-1:0] row_raddr, row_waddr;
  upd_stat_t     stat;
  agg_t          agg;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign in_range_in = ({23'd0, in_page} < 32'(PAGE_COUNT));
  assign surf_ok_in  = ({24'd0, in_surface} < 32'(SURFACE_COUNT));
  assign idx_in      = PW'({23'd0, in_page});
  assign destroy_go  = (in_kind == K_DESTROY) && surf_ok_in;
  assign out_free    = !out_valid || out_ready;
  assign go          = (state_r == S_EXEC) && out_free;
  assign active      = go && in_range_r && (kind_r <= K_EPOCH_Q);
  assign load        = ((state_r == S_EXEC) || (state_r == S_DONE)) && out_free;
  assign rst_row     = {PLANE_COUNT{RST_ENT}};
  assign walk_step   = (state_r == S_WALK) && (cnt_r != LAST);

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r     <= kind_t'(in_kind);
      idx_r      <= idx_in;
      sel_r      <= in_plane_select;
      surf_r     <= in_surface;
      blocks_r   <= in_edge_blocks;
      full_r     <= in_edge_full;
      edge_r     <= in_on_edge;
      ovf_r      <= in_overflowed;
      first_r    <= in_first;
      epoch_r    <= in_epoch;
      in_range_r <= in_range_in;
      surf_ok_r  <= surf_ok_in;
    end
  end

  pbcd_row_update #(
    .PLANE_COUNT  (PLANE_COUNT),
    .SURFACE_COUNT(SURFACE_COUNT)
  ) u_upd (
    .walk      (state_r == S_WALK),
    .active    (active),
    .kind      (kind_r),
    .sel       (sel_r),
    .surface   (OWNER_W'(surf_r)),
    .surface_ok(surf_ok_r),
    .blocks    (blocks_r),
    .full      (full_r),
    .on_edge   (edge_r),
    .ovf       (ovf_r),
    .row_i     (row_q),
    .row_o     (row_upd),
    .stat_o    (stat)
  );

  pbcd_agg #(
    .PLANE_COUNT  (PLANE_COUNT),
    .SURFACE_COUNT(SURFACE_COUNT)
  ) u_agg (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (active),
    .kind      (kind_r),
    .first     (first_r),
    .sel       (sel_r),
    .row_i     (row_q),
    .page_epoch(page_q.epoch),
    .refute    (stat.refute),
    .agg_nxt   (agg)
  );

  always_comb begin
    page_upd = page_q;
    case (kind_r)
      K_CPU_WRITE: page_upd.cgen = page_q.cgen + 32'd1;
      K_DRAW:      if (surf_ok_r) page_upd.ggen = page_q.ggen + 32'd1;
      K_STAMP:     if (epoch_r > page_q.epoch) page_upd.epoch = epoch_r;
      default: ;
    endcase
  end

  // memory ports: read on accept and during the walk, write in clear, walk and modify
  always_comb begin
    row_rd    = accept || ((state_r == S_WALK) && (cnt_r != LAST));
    row_raddr = accept ? (destroy_go ? '0 : idx_in) : cnt_r + PW'(1);
    row_we    = (state_r == S_CLR) || (state_r == S_WALK) || active;
    row_waddr = ((state_r == S_CLR) || (state_r == S_WALK)) ? cnt_r : idx_r;
    row_wd    = (state_r == S_CLR) ? rst_row : row_upd;
    page_we   = (state_r == S_CLR) || (active && (kind_r == K_CPU_WRITE ||
                kind_r == K_DRAW || kind_r == K_STAMP));
    page_wd   = (state_r == S_CLR) ? page_t'('0) : page_upd;
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wd;
    if (row_rd) row_q <= row_mem[row_raddr];
    if (page_we) page_mem[row_waddr] <= page_wd;
    if (accept) page_q <= page_mem[idx_in];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_CLR: begin
          cnt_r <= cnt_r + PW'(1);
          if (cnt_r == LAST) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cnt_r   <= '0;
            state_r <= destroy_go ? S_WALK : S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) state_r <= S_IDLE;
        end
        S_WALK: begin
          if (cnt_r == LAST) state_r <= S_DONE;
          else cnt_r <= cnt_r + PW'(1);
        end
        S_DONE: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_need          <= stat.need;
      out_owner_valid   <= agg.sole;
      out_owner         <= agg.owner;
      out_max_epoch     <= agg.epoch;
      out_refuted_count <= agg.refuted;
      out_cpu_writes    <= in_range_r ? page_upd.cgen : 32'd0;
      out_gpu_writes    <= in_range_r ? page_upd.ggen : 32'd0;
    end
  end

  `PBCD_ASSERT(a_accept_starts_work, clk, rst_n, accept |=> (state_r == S_EXEC || state_r == S_WALK))
  `PBCD_ASSERT(a_load_only_when_free, clk, rst_n, load |-> (!out_valid || out_ready))
  `PBCD_ASSERT(a_walk_advances, clk, rst_n, walk_step |=> (cnt_r == $past(cnt_r) + PW'(1)))
  `PBCD_ASSERT(a_no_write_idle, clk, rst_n, (row_we || page_we) |-> (state_r != S_IDLE))

endmodule
`default_nettype wire
